// ===== src/laser_scan_occupancy_grid_assert.svh =====
// assertion macros for the laser scan occupancy grid
`ifndef LASER_SCAN_OCCUPANCY_GRID_ASSERT_SVH
`define LASER_SCAN_OCCUPANCY_GRID_ASSERT_SVH

// clocked check, off while reset is low
`define LSOG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds while reset is low
`define LSOG_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/lsog_pkg.sv =====
// shared types and constants of the laser scan occupancy grid
package lsog_pkg;

  // item kinds
  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NOP    = 2'd3
  } kind_e;

  // register indexes
  localparam logic [1:0] CFG_MIN_RANGE  = 2'd0;
  localparam logic [1:0] CFG_MAX_RANGE  = 2'd1;
  localparam logic [1:0] CFG_ANGLE_STEP = 2'd2;

  localparam logic [15:0] MIN_RANGE_RST  = 16'd512;
  localparam logic [15:0] MAX_RANGE_RST  = 16'd30720;
  localparam logic [15:0] ANGLE_STEP_RST = 16'd91;

  // grid geometry
  localparam int GRID_COLS_DEF = 80;
  localparam int GRID_ROWS_DEF = 60;
  localparam int CELL_UNITS    = 256;
  localparam int CELL_SHIFT    = $clog2(CELL_UNITS);
  localparam int BEAM_BITS     = 12;

  // sine polynomial, constant term last and used last
  localparam logic [15:0] POLY_E = 16'd5;
  localparam logic [15:0] POLY_C [4] = '{16'd153, 16'd2611, 16'd21167, 16'd51472};

  // what travels beside the angle
  typedef struct packed {
    kind_e       kind;
    logic [15:0] range;
    logic [6:0]  addr;
  } side_t;

  // map operation after binning
  typedef struct packed {
    kind_e      kind;
    logic       hit;
    logic [6:0] col;
    logic [5:0] row;
    logic [6:0] addr;
  } map_op_t;

endpackage

// ===== src/laser_scan_occupancy_grid.sv =====
// Laser scan to occupancy grid: clear, range sample or map word read per item.
// Stages: 1 input stage, 6 sine and cosine stages, 2 rotate and bin stages and
// 1 map stage with output register. Throughput: one item per cycle while the
// output is not stalled; every stage is a multiply or a map access.
// Reset: registers take their reset values, the pipeline empties and the map
// reads all zero at once through per-word valid bits; no clearing pass.
module laser_scan_occupancy_grid import lsog_pkg::*; #(
  parameter int GRID_COLS = GRID_COLS_DEF,
  parameter int GRID_ROWS = GRID_ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // beam_index, range_sample, word_address
  input  logic [1:0]  s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // cell_column, cell_row, map_word
  output logic [0:0]  m_axis_tuser,   // cell_hit
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int CellW = $clog2(GRID_COLS * GRID_ROWS);

  logic [15:0] min_range_q;
  logic [15:0] max_range_q;
  logic [15:0] angle_step_q;

  logic        in_valid_q;
  logic        in_en;
  logic [15:0] theta_q;
  side_t       side_q;

  logic [BEAM_BITS-1:0] beam;
  logic [15:0]          range_in;
  logic [15:0]          range_c;

  logic               sc_ready;
  logic               sc_valid;
  logic signed [17:0] sc_sin;
  logic signed [17:0] sc_cos;
  side_t              sc_side;

  logic             bin_ready;
  logic             bin_valid;
  map_op_t          bin_op;
  logic [CellW-1:0] bin_cell;

  logic        map_ready;
  logic        res_hit;
  logic [6:0]  res_col;
  logic [5:0]  res_row;
  logic [63:0] res_word;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_range_q  <= MIN_RANGE_RST;
      max_range_q  <= MAX_RANGE_RST;
      angle_step_q <= ANGLE_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MIN_RANGE:  min_range_q  <= cfg_data_i;
        CFG_MAX_RANGE:  max_range_q  <= cfg_data_i;
        CFG_ANGLE_STEP: angle_step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input stage: beam angle, and ranges outside the limits replaced by max range
  assign beam     = BEAM_BITS'(s_axis_tdata[11:0]);
  assign range_in = s_axis_tdata[27:12];
  assign range_c  = (range_in <= min_range_q || range_in >= max_range_q) ?
                    max_range_q : range_in;

  assign in_en         = !in_valid_q || sc_ready;
  assign s_axis_tready = in_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_en) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_en) begin
      theta_q     <= 16'(32'(beam) * 32'(angle_step_q));
      side_q.kind  <= kind_e'(s_axis_tuser);
      side_q.range <= range_c;
      side_q.addr  <= s_axis_tdata[34:28];
    end
  end

  lsog_sincos u_sincos (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_q),
    .in_ready_o  (sc_ready),
    .theta_i     (theta_q),
    .side_i      (side_q),
    .out_valid_o (sc_valid),
    .out_ready_i (bin_ready),
    .sin_o       (sc_sin),
    .cos_o       (sc_cos),
    .side_o      (sc_side)
  );

  lsog_bin #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS),
    .CellW     (CellW)
  ) u_bin (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sc_valid),
    .in_ready_o  (bin_ready),
    .sin_i       (sc_sin),
    .cos_i       (sc_cos),
    .side_i      (sc_side),
    .out_valid_o (bin_valid),
    .out_ready_i (map_ready),
    .op_o        (bin_op),
    .cell_o      (bin_cell)
  );

  lsog_map #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS),
    .CellW     (CellW)
  ) u_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (bin_valid),
    .in_ready_o  (map_ready),
    .op_i        (bin_op),
    .cell_i      (bin_cell),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .hit_o       (res_hit),
    .col_o       (res_col),
    .row_o       (res_row),
    .map_word_o  (res_word)
  );

  // result packing
  assign m_axis_tdata = {3'd0, res_word, res_row, res_col};
  assign m_axis_tuser = res_hit;

endmodule

// ===== src/lsog_sincos.sv =====
// pipelined fixed-point sine and cosine, one polynomial step per stage
module lsog_sincos import lsog_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        theta_i,
  input  side_t              side_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [17:0] sin_o,
  output logic signed [17:0] cos_o,
  output side_t              side_o
);

  localparam int Stages = 6;

  logic [Stages-1:0] valid_q;
  logic [Stages-1:0] en;
  side_t             side_q [Stages];
  logic [16:0]       z_q    [5][2];
  logic [16:0]       z2_q   [4][2];
  logic [15:0]       p_q    [4][2];
  logic              neg_q  [5][2];
  logic signed [17:0] s_q   [2];

  logic [15:0] th   [2];
  logic [16:0] z0   [2];
  logic        neg0 [2];

  // stage enables, back to front
  always_comb begin
    en[Stages-1] = !valid_q[Stages-1] || out_ready_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // quadrant fold: lane 0 sine, lane 1 cosine
  always_comb begin
    th[0] = theta_i;
    th[1] = theta_i + 16'd16384;
    for (int l = 0; l < 2; l++) begin
      if (th[l][14]) begin
        z0[l] = 17'h10000 - {1'b0, th[l][13:0], 2'b00};
      end else begin
        z0[l] = {1'b0, th[l][13:0], 2'b00};
      end
      neg0[l] = th[l][15];
    end
  end

  // stage 0: fold and square
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0] <= side_i;
      for (int l = 0; l < 2; l++) begin
        z_q[0][l]   <= z0[l];
        neg_q[0][l] <= neg0[l];
        z2_q[0][l]  <= 17'((34'(z0[l]) * 34'(z0[l])) >> 16);
      end
    end
  end

  // stages 1 to 4: horner steps
  for (genvar k = 1; k < 5; k++) begin : g_poly
    logic [15:0] prev [2];
    always_comb begin
      for (int l = 0; l < 2; l++) begin
        prev[l] = (k == 1) ? POLY_E : p_q[(k > 1) ? k - 2 : 0][l];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
        for (int l = 0; l < 2; l++) begin
          z_q[k][l]   <= z_q[k-1][l];
          neg_q[k][l] <= neg_q[k-1][l];
          p_q[k-1][l] <= POLY_C[k-1] - 16'((34'(z2_q[k-1][l]) * 34'(prev[l])) >> 16);
        end
      end
    end
    if (k < 4) begin : g_sq
      always_ff @(posedge clk_i) begin
        if (en[k]) begin
          z2_q[k] <= z2_q[k-1];
        end
      end
    end
  end

  // stage 5: final product and sign
  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      side_q[5] <= side_q[4];
      for (int l = 0; l < 2; l++) begin
        if (neg_q[4][l]) begin
          s_q[l] <= -$signed({1'b0, 17'((34'(z_q[4][l]) * 34'(p_q[3][l])) >> 16)});
        end else begin
          s_q[l] <= $signed({1'b0, 17'((34'(z_q[4][l]) * 34'(p_q[3][l])) >> 16)});
        end
      end
    end
  end

  assign out_valid_o = valid_q[Stages-1];
  assign sin_o       = s_q[0];
  assign cos_o       = s_q[1];
  assign side_o      = side_q[Stages-1];

endmodule

// ===== src/lsog_bin.sv =====
// rotation to x and y, then binning into a grid cell
module lsog_bin import lsog_pkg::*; #(
  parameter int GRID_COLS = GRID_COLS_DEF,
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int CellW     = $clog2(GRID_COLS * GRID_ROWS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [17:0] sin_i,
  input  logic signed [17:0] cos_i,
  input  side_t              side_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output map_op_t            op_o,
  output logic [CellW-1:0]   cell_o
);

  localparam int XOrigin = GRID_COLS / 2 * CELL_UNITS;

  logic [1:0]         valid_q;
  logic [1:0]         en;
  side_t              side_q;
  logic signed [17:0] x_q;
  logic signed [17:0] y_q;
  map_op_t            op_q;
  logic [CellW-1:0]   cell_q;

  logic signed [34:0] px;
  logic signed [34:0] py;
  logic signed [19:0] xs;
  logic signed [19:0] col_w;
  logic signed [19:0] row_w;
  logic               hit;

  assign en[1]      = !valid_q[1] || out_ready_i;
  assign en[0]      = !valid_q[0] || en[1];
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= in_valid_i;
      if (en[1]) valid_q[1] <= valid_q[0];
    end
  end

  // range times sine and cosine, floor by 2^15
  always_comb begin
    px = $signed({1'b0, side_i.range}) * cos_i;
    py = $signed({1'b0, side_i.range}) * sin_i;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q <= side_i;
      x_q    <= 18'(px >>> 15);
      y_q    <= 18'(py >>> 15);
    end
  end

  // cell from x and y, rounding down
  always_comb begin
    xs    = 20'(x_q) + 20'(XOrigin);
    col_w = xs >>> CELL_SHIFT;
    row_w = 20'(y_q) >>> CELL_SHIFT;
    hit   = (side_q.kind == ACT_SAMPLE) && (col_w >= 0) && (col_w < GRID_COLS)
            && (row_w >= 0) && (row_w < GRID_ROWS);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      op_q.kind <= side_q.kind;
      op_q.addr <= side_q.addr;
      op_q.hit  <= hit;
      op_q.col  <= hit ? 7'(col_w) : 7'd0;
      op_q.row  <= hit ? 6'(row_w) : 6'd0;
      cell_q    <= CellW'(32'(col_w[7:0]) * 32'(GRID_ROWS) + 32'(row_w[7:0]));
    end
  end

  assign out_valid_o = valid_q[1];
  assign op_o        = op_q;
  assign cell_o      = cell_q;

endmodule

// ===== src/lsog_map.sv =====
// occupancy bitmap memory with per-word valid bits and output register
module lsog_map import lsog_pkg::*; #(
  parameter int GRID_COLS = GRID_COLS_DEF,
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int CellW     = $clog2(GRID_COLS * GRID_ROWS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  map_op_t          op_i,
  input  logic [CellW-1:0] cell_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             hit_o,
  output logic [6:0]       col_o,
  output logic [5:0]       row_o,
  output logic [63:0]      map_word_o
);

  localparam int MapWords = (GRID_COLS * GRID_ROWS + 63) / 64;
  localparam int WordW    = (MapWords > 1) ? $clog2(MapWords) : 1;

  logic [63:0]         mem_q [MapWords];
  logic [MapWords-1:0] word_valid_q;
  logic                valid_q;
  logic                hit_q;
  logic [6:0]          col_q;
  logic [5:0]          row_q;
  logic [63:0]         rd_q;
  logic                rd_ok_q;

  logic               en;
  logic               take;
  logic [CellW+5:0]   cell_x;
  logic [WordW-1:0]   wr_word;
  logic [63:0]        wr_bit;
  logic [63:0]        wr_mask;
  logic [WordW-1:0]   rd_word;
  logic               rd_ok;

  assign en         = !valid_q || out_ready_i;
  assign in_ready_o = en;
  assign take       = in_valid_i && en;

  // word and bit of the cell
  always_comb begin
    cell_x  = (CellW + 6)'(cell_i);
    wr_word = WordW'(cell_x >> 6);
    wr_bit  = 64'd1 << cell_x[5:0];
    wr_mask = word_valid_q[wr_word] ? wr_bit : '1;
    rd_word = WordW'(op_i.addr);
    rd_ok   = (op_i.kind == ACT_READ) && (32'(op_i.addr) < MapWords)
              && word_valid_q[rd_word];
  end

  // valid bits: a word not yet written since a clear reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_valid_q <= '0;
      valid_q      <= 1'b0;
    end else begin
      if (en) valid_q <= in_valid_i;
      if (take && op_i.kind == ACT_CLEAR) begin
        word_valid_q <= '0;
      end else if (take && op_i.hit) begin
        word_valid_q[wr_word] <= 1'b1;
      end
    end
  end

  // bit-masked write, registered read
  always_ff @(posedge clk_i) begin
    if (take && op_i.hit) begin
      for (int b = 0; b < 64; b++) begin
        if (wr_mask[b]) mem_q[wr_word][b] <= wr_bit[b];
      end
    end
    if (take && op_i.kind == ACT_READ) begin
      rd_q <= mem_q[rd_word];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q   <= op_i.hit;
      col_q   <= op_i.col;
      row_q   <= op_i.row;
      rd_ok_q <= rd_ok;
    end
  end

  assign out_valid_o = valid_q;
  assign hit_o       = hit_q;
  assign col_o       = col_q;
  assign row_o       = row_q;
  assign map_word_o  = rd_ok_q ? rd_q : 64'd0;

endmodule

// ===== src/lsog_checker.sv =====
// port-level checks of the occupancy grid block and their binding
`include "laser_scan_occupancy_grid_assert.svh"

module lsog_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [39:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        cfg_we_i,
  input logic [1:0]  cfg_index_i,
  input logic [15:0] cfg_data_i
);

  // a stalled result holds
  `LSOG_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // a miss reports no cell
  `LSOG_ASSERT(a_miss_no_cell, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[12:0] == 13'd0, "cell reported without hit")

  // a hit carries no map word and no pad bits
  `LSOG_ASSERT(a_hit_no_word, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[79:13] == 67'd0, "map word beside a hit")

  // nothing comes out while reset is low
  `LSOG_ASSERT_RST(a_reset_empty, !rst_ni |-> !m_axis_tvalid, "result valid in reset")

endmodule

bind laser_scan_occupancy_grid lsog_checker u_lsog_checker (.*);
